FILE: rtl/ctcg_pkg.sv
`default_nettype none

package ctcg_pkg;

    // Fixed field widths of the stream items
    localparam int LOGIT_W   = 16;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CLS_OUT_W = 14;
    localparam int CNT_OUT_W = 11;
    localparam int OUT_TDATA_W = 48;

    // Width used for class and size comparisons (holds MAX_CLASSES up to 65536)
    localparam int CMP_W = 17;

    // Parameter defaults
    localparam int DEF_MAX_CLASSES = 16384;
    localparam int DEF_MAX_STEPS   = 1024;

    // Depth of the queue between front and back, a power of two
    localparam int QUEUE_DEPTH = 4;

    // Register reset values
    localparam logic [CFG_W-1:0] CLASS_COUNT_RST = 15'd6625;
    localparam logic [CFG_W-1:0] DICT_SIZE_RST   = 15'd6625;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DICT_SIZE   = 2'd1;

    // Result kinds
    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        B_IDLE,
        B_CHAR,
        B_DIV,
        B_SUM
    } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/ctcg_front.sv
`default_nettype none

module ctcg_front #(
    parameter int MAX_CLASSES = ctcg_pkg::DEF_MAX_CLASSES,
    parameter int MAX_STEPS   = ctcg_pkg::DEF_MAX_STEPS,
    parameter int CLS_W       = $clog2(MAX_CLASSES),
    parameter int CNT_W       = $clog2(MAX_STEPS + 1),
    parameter int TOT_W       = ctcg_pkg::LOGIT_W + CNT_W
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [ctcg_pkg::CFG_W-1:0]          class_count,
    input  wire logic [ctcg_pkg::CFG_W-1:0]          dict_size,
    input  wire logic                                item_valid,
    output logic                                     item_ready,
    input  wire logic signed [ctcg_pkg::LOGIT_W-1:0] logit,
    input  wire logic                                end_of_sequence,
    input  wire logic                                queue_full,
    output logic                                     push,
    output logic                                     ent_char,
    output logic                                     ent_eos,
    output logic [CLS_W-1:0]                         ent_class,
    output logic signed [ctcg_pkg::LOGIT_W-1:0]      ent_score,
    output logic                                     ent_in_dict,
    output logic signed [TOT_W-1:0]                  ent_total,
    output logic [CNT_W-1:0]                         ent_count
);
    import ctcg_pkg::*;

    logic signed [LOGIT_W-1:0] best_score_reg, best_score_next;
    logic [CLS_W-1:0]          best_class_reg, best_class_next;
    logic [CLS_W-1:0]          position_reg, position_next;
    logic [CLS_W-1:0]          prev_class_reg, prev_class_next;
    logic                      prev_valid_reg, prev_valid_next;
    logic signed [TOT_W-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]          count_reg, count_next;

    logic                      accept;
    logic [CMP_W-1:0]          eff_count;
    logic signed [LOGIT_W-1:0] cur_score;
    logic [CLS_W-1:0]          cur_class;
    logic                      step_done;
    logic                      repeat_hit;
    logic                      emit;
    logic                      counted;
    logic signed [TOT_W-1:0]   total_add;

    assign item_ready = !queue_full;
    assign accept     = item_valid && item_ready;

    // Track the step maximum and decide what the item closes
    always_comb
    begin
        eff_count = (CMP_W'(class_count) > CMP_W'(MAX_CLASSES)) ?
                    CMP_W'(MAX_CLASSES) : CMP_W'(class_count);
        if (position_reg == '0)
        begin
            cur_score = logit;
            cur_class = '0;
        end
        else if (logit > best_score_reg)
        begin
            cur_score = logit;
            cur_class = position_reg;
        end
        else
        begin
            cur_score = best_score_reg;
            cur_class = best_class_reg;
        end
        step_done  = end_of_sequence || ((CMP_W'(position_reg) + 1'b1) >= eff_count);
        repeat_hit = prev_valid_reg && (prev_class_reg == cur_class);
        emit       = step_done && !repeat_hit && (cur_class != '0);
        counted    = emit && (count_reg < CNT_W'(MAX_STEPS));
        total_add  = total_reg + TOT_W'(cur_score);
    end

    // Build the queue entry for a character and/or a sequence end
    always_comb
    begin
        push        = accept && (emit || end_of_sequence);
        ent_char    = emit;
        ent_eos     = end_of_sequence;
        ent_class   = cur_class;
        ent_score   = cur_score;
        ent_in_dict = CMP_W'(cur_class) < CMP_W'(dict_size);
        ent_total   = counted ? total_add : total_reg;
        ent_count   = counted ? count_reg + 1'b1 : count_reg;
    end

    // Advance the sequence state
    always_comb
    begin
        best_score_next = best_score_reg;
        best_class_next = best_class_reg;
        position_next   = position_reg;
        prev_class_next = prev_class_reg;
        prev_valid_next = prev_valid_reg;
        total_next      = total_reg;
        count_next      = count_reg;
        if (accept)
        begin
            best_score_next = cur_score;
            best_class_next = cur_class;
            if (end_of_sequence)
            begin
                best_score_next = '0;
                best_class_next = '0;
                position_next   = '0;
                prev_class_next = '0;
                prev_valid_next = 1'b0;
                total_next      = '0;
                count_next      = '0;
            end
            else if (step_done)
            begin
                position_next = '0;
                if (!repeat_hit)
                begin
                    prev_class_next = cur_class;
                    prev_valid_next = 1'b1;
                end
                total_next = ent_total;
                count_next = ent_count;
            end
            else
            begin
                position_next = position_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_score_reg <= '0;
            best_class_reg <= '0;
            position_reg   <= '0;
            prev_class_reg <= '0;
            prev_valid_reg <= 1'b0;
            total_reg      <= '0;
            count_reg      <= '0;
        end
        else
        begin
            best_score_reg <= best_score_next;
            best_class_reg <= best_class_next;
            position_reg   <= position_next;
            prev_class_reg <= prev_class_next;
            prev_valid_reg <= prev_valid_next;
            total_reg      <= total_next;
            count_reg      <= count_next;
        end
    end

    // The counted characters never pass the step limit
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_STEPS))
        else $error("character count above limit");

    // A sequence end leaves the state cleared
    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_sequence) |=> (count_reg == '0) && (total_reg == '0)
        && (position_reg == '0) && !prev_valid_reg)
        else $error("sequence state not cleared at end");

    // A closed step restarts the class position
    a_step_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && step_done) |=> (position_reg == '0))
        else $error("class position not restarted");

endmodule

`default_nettype wire

FILE: rtl/ctcg_queue.sv
`default_nettype none

module ctcg_queue #(
    parameter int W     = 8,
    parameter int DEPTH = ctcg_pkg::QUEUE_DEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_en,
    input  wire logic [W-1:0] wr_data,
    input  wire logic         rd_en,
    output logic [W-1:0]      rd_data,
    output logic              full,
    output logic              empty
);
    import ctcg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold request payloads
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty)
        else $error("queue read while empty");

    a_level: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue level not advanced on write");

endmodule

`default_nettype wire

FILE: rtl/ctcg_div.sv
`default_nettype none

module ctcg_div #(
    parameter int TOT_W = 27,
    parameter int CNT_W = 11
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [TOT_W-1:0]             dividend,
    input  wire logic [CNT_W-1:0]                    divisor,
    output logic                                     busy,
    output logic                                     done,
    output logic signed [ctcg_pkg::LOGIT_W-1:0]      quotient
);
    import ctcg_pkg::*;

    localparam int STEP_W = $clog2(TOT_W + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [TOT_W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]     dvs_reg, dvs_next;
    logic                 neg_reg, neg_next;
    logic [CNT_W:0]       trial;
    logic                 fits;

    // Restoring division of the magnitude, one quotient bit per cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[TOT_W-1]};
        fits      = trial >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            dvs_next  = divisor;
            rem_next  = '0;
            step_next = STEP_W'(TOT_W);
            if (divisor == '0)
            begin
                quo_next  = '0;
                neg_next  = 1'b0;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                quo_next  = dividend[TOT_W-1] ? TOT_W'(-dividend) : TOT_W'(dividend);
                neg_next  = dividend[TOT_W-1];
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? CNT_W'(trial - {1'b0, dvs_reg}) : CNT_W'(trial);
            quo_next  = {quo_reg[TOT_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? -LOGIT_W'(quo_reg) : LOGIT_W'(quo_reg);

endmodule

`default_nettype wire

FILE: rtl/ctcg_back.sv
`default_nettype none

module ctcg_back #(
    parameter int CLS_W = 14,
    parameter int CNT_W = 11,
    parameter int TOT_W = 27
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                queue_empty,
    output logic                                     pop,
    input  wire logic                                ent_char,
    input  wire logic                                ent_eos,
    input  wire logic [CLS_W-1:0]                    ent_class,
    input  wire logic signed [ctcg_pkg::LOGIT_W-1:0] ent_score,
    input  wire logic                                ent_in_dict,
    input  wire logic signed [TOT_W-1:0]             ent_total,
    input  wire logic [CNT_W-1:0]                    ent_count,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     out_kind,
    output logic [ctcg_pkg::CLS_OUT_W-1:0]           out_class,
    output logic signed [ctcg_pkg::LOGIT_W-1:0]      out_score,
    output logic                                     out_in_dict,
    output logic [ctcg_pkg::CNT_OUT_W-1:0]           out_count,
    output logic                                     out_last
);
    import ctcg_pkg::*;

    back_state_t state_reg, state_next;

    // Entry held while it is carried out
    logic                      eos_reg;
    logic [CLS_W-1:0]          class_reg;
    logic signed [LOGIT_W-1:0] score_reg;
    logic                      in_dict_reg;
    logic signed [TOT_W-1:0]   total_reg;
    logic [CNT_W-1:0]          count_reg;

    // Output register
    logic                      ovalid_reg, ovalid_next;
    logic                      okind_reg;
    logic [CLS_OUT_W-1:0]      oclass_reg;
    logic signed [LOGIT_W-1:0] oscore_reg;
    logic                      odict_reg;
    logic [CNT_OUT_W-1:0]      ocount_reg;
    logic                      olast_reg;

    logic                      out_free;
    logic                      div_start;
    logic                      div_busy;
    logic                      div_done;
    logic signed [LOGIT_W-1:0] div_quotient;
    logic                      load_char;
    logic                      load_sum;
    logic signed [TOT_W-1:0]   div_dividend;
    logic [CNT_W-1:0]          div_divisor;

    assign out_free = !ovalid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!queue_empty)
                begin
                    state_next = ent_char ? B_CHAR : B_DIV;
                end
            end
            B_CHAR:
            begin
                if (out_free)
                begin
                    state_next = eos_reg ? B_DIV : B_IDLE;
                end
            end
            B_DIV:
            begin
                if (div_done)
                begin
                    state_next = B_SUM;
                end
            end
            B_SUM:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        pop          = 1'b0;
        div_start    = 1'b0;
        load_char    = 1'b0;
        load_sum     = 1'b0;
        div_dividend = total_reg;
        div_divisor  = count_reg;
        case (state_reg)
            B_IDLE:
            begin
                pop          = !queue_empty;
                div_start    = !queue_empty && !ent_char;
                div_dividend = ent_total;
                div_divisor  = ent_count;
            end
            B_CHAR:
            begin
                load_char = out_free;
                div_start = out_free && eos_reg;
            end
            B_SUM:
            begin
                load_sum = out_free;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Capture the entry on pop
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            eos_reg     <= ent_eos;
            class_reg   <= ent_class;
            score_reg   <= ent_score;
            in_dict_reg <= ent_in_dict;
            total_reg   <= ent_total;
            count_reg   <= ent_count;
        end
    end

    ctcg_div #(
        .TOT_W (TOT_W),
        .CNT_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Hold the result until the receiver takes it
    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (load_char || load_sum)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_char)
        begin
            okind_reg  <= KIND_CHAR;
            oclass_reg <= CLS_OUT_W'(class_reg);
            oscore_reg <= score_reg;
            odict_reg  <= in_dict_reg;
            ocount_reg <= '0;
            olast_reg  <= 1'b0;
        end
        else if (load_sum)
        begin
            okind_reg  <= KIND_SUMMARY;
            oclass_reg <= '0;
            oscore_reg <= div_quotient;
            odict_reg  <= 1'b0;
            ocount_reg <= CNT_OUT_W'(count_reg);
            olast_reg  <= 1'b1;
        end
    end

    assign out_valid   = ovalid_reg;
    assign out_kind    = okind_reg;
    assign out_class   = oclass_reg;
    assign out_score   = oscore_reg;
    assign out_in_dict = odict_reg;
    assign out_count   = ocount_reg;
    assign out_last    = olast_reg;

    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == B_DIV))
        else $error("divider running outside the divide state");

    a_sum_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_SUM) |-> !div_busy)
        else $error("summary taken while divider still running");

    a_empty_avg: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(div_done) && (count_reg == '0) && !pop |=> (div_quotient == '0))
        else $error("average of an empty sequence not zero");

endmodule

`default_nettype wire

FILE: rtl/ctc_greedy_decoder.sv
// Greedy CTC decoder.
// s_* stream: one class score per request, class-major within each time step;
//   s_tlast marks the last score of a sequence.
// cfg_* channel: register writes (class_count, dict_size), always ready;
//   write only while the block is idle.
// m_* stream: character results (tuser = 0) for each new non-blank winner,
//   and one summary (tuser = 1, tlast = 1) per sequence with the truncated
//   mean score and the character count.
// Throughput: one score per cycle into a 4-entry queue between the decode
//   front and the back end. The back end takes a new entry only once it is done
//   with the last, and a summary waits on the bit-serial divider; s_tready
//   drops only when the queue is full.
// Path: a character's entry passes the queue, the back end's entry register and
//   the output register; a summary also waits for the divider, and follows the
//   last step's character when that step emits one.
// Reset: registers return to 6625 classes and dictionary size, sequence state
//   and the queue are cleared, no result is pending.
// Receiver stall: the result waits in the output register; decoding continues
//   until the queue fills.
`default_nettype none

module ctc_greedy_decoder #(
    parameter int MAX_CLASSES = ctcg_pkg::DEF_MAX_CLASSES,
    parameter int MAX_STEPS   = ctcg_pkg::DEF_MAX_STEPS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [ctcg_pkg::LOGIT_W-1:0]         s_tdata,  // [15:0] logit
    input  wire logic                                 s_tlast,  // end_of_sequence
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // [13:0] class_index, [29:14] score, [30] in_dictionary,
    // [41:31] char_count, [47:42] zero
    output logic [ctcg_pkg::OUT_TDATA_W-1:0]          m_tdata,
    output logic                                      m_tuser,  // [0] kind
    output logic                                      m_tlast,  // last
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [ctcg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [ctcg_pkg::CFG_W-1:0]           cfg_data
);
    import ctcg_pkg::*;

    localparam int CLS_W = $clog2(MAX_CLASSES);
    localparam int CNT_W = $clog2(MAX_STEPS + 1);
    localparam int TOT_W = LOGIT_W + CNT_W;
    localparam int ENT_W = 3 + CLS_W + LOGIT_W + TOT_W + CNT_W;

    logic [CFG_W-1:0]          class_count_reg;
    logic [CFG_W-1:0]          dict_size_reg;

    logic                      push;
    logic                      pop;
    logic                      queue_full;
    logic                      queue_empty;
    logic [ENT_W-1:0]          wr_entry;
    logic [ENT_W-1:0]          rd_entry;

    logic                      f_char;
    logic                      f_eos;
    logic [CLS_W-1:0]          f_class;
    logic signed [LOGIT_W-1:0] f_score;
    logic                      f_dict;
    logic signed [TOT_W-1:0]   f_total;
    logic [CNT_W-1:0]          f_count;

    logic                      b_char;
    logic                      b_eos;
    logic [CLS_W-1:0]          b_class;
    logic signed [LOGIT_W-1:0] b_score;
    logic                      b_dict;
    logic signed [TOT_W-1:0]   b_total;
    logic [CNT_W-1:0]          b_count;

    logic [CLS_OUT_W-1:0]      o_class;
    logic signed [LOGIT_W-1:0] o_score;
    logic                      o_dict;
    logic [CNT_OUT_W-1:0]      o_count;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_count_reg <= CLASS_COUNT_RST;
            dict_size_reg   <= DICT_SIZE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CLASS_COUNT: class_count_reg <= cfg_data;
                CFG_DICT_SIZE:   dict_size_reg   <= cfg_data;
                default:         class_count_reg <= class_count_reg;
            endcase
        end
    end

    ctcg_front #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_STEPS   (MAX_STEPS),
        .CLS_W       (CLS_W),
        .CNT_W       (CNT_W),
        .TOT_W       (TOT_W)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .class_count     (class_count_reg),
        .dict_size       (dict_size_reg),
        .item_valid      (s_tvalid),
        .item_ready      (s_tready),
        .logit           (s_tdata),
        .end_of_sequence (s_tlast),
        .queue_full      (queue_full),
        .push            (push),
        .ent_char        (f_char),
        .ent_eos         (f_eos),
        .ent_class       (f_class),
        .ent_score       (f_score),
        .ent_in_dict     (f_dict),
        .ent_total       (f_total),
        .ent_count       (f_count)
    );

    // Pack and unpack queue entries
    assign wr_entry = {f_char, f_eos, f_dict, f_class, f_score, f_total, f_count};
    assign {b_char, b_eos, b_dict, b_class, b_score, b_total, b_count} = rd_entry;

    ctcg_queue #(
        .W     (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (wr_entry),
        .rd_en   (pop),
        .rd_data (rd_entry),
        .full    (queue_full),
        .empty   (queue_empty)
    );

    ctcg_back #(
        .CLS_W (CLS_W),
        .CNT_W (CNT_W),
        .TOT_W (TOT_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .pop         (pop),
        .ent_char    (b_char),
        .ent_eos     (b_eos),
        .ent_class   (b_class),
        .ent_score   (b_score),
        .ent_in_dict (b_dict),
        .ent_total   (b_total),
        .ent_count   (b_count),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (m_tuser),
        .out_class   (o_class),
        .out_score   (o_score),
        .out_in_dict (o_dict),
        .out_count   (o_count),
        .out_last    (m_tlast)
    );

    assign m_tdata = {6'd0, o_count, o_dict, o_score, o_class};

endmodule

`default_nettype wire
